[rtl/quoted_command_line_tokenizer_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quoted command line tokenizer.
// ----------------------------------------------------------------------------
`ifndef QUOTED_COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define QUOTED_COMMAND_LINE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QCT_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define QCT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

[rtl/qct_pkg.sv]
// ----------------------------------------------------------------------------
// qct_pkg
// Shared codes, byte constants and types of the command line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package qct_pkg;

    // Scan modes.
    localparam logic [2:0] MODE_LINE_START = 3'd0;
    localparam logic [2:0] MODE_MARK_ONE   = 3'd1;
    localparam logic [2:0] MODE_MARK_TWO   = 3'd2;
    localparam logic [2:0] MODE_GAP        = 3'd3;
    localparam logic [2:0] MODE_BARE       = 3'd4;
    localparam logic [2:0] MODE_SINGLE     = 3'd5;
    localparam logic [2:0] MODE_DOUBLE     = 3'd6;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_OK    = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Special bytes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] MARK_B0   = 8'hEF;
    localparam logic [7:0] MARK_B1   = 8'hBB;
    localparam logic [7:0] MARK_B2   = 8'hBF;

    // Most result words one input byte can cause.
    localparam int MAX_RES = 4;

    // One result word.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] token_byte;
        logic       first_in_token;
        logic       last_of_run;
    } t_res;

    // All result words of one input byte.
    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [2:0]         num;
    } t_batch;

endpackage

`default_nettype wire

[rtl/quoted_command_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// quoted_command_line_tokenizer
// Splits a zero-terminated command line into tokens, bare or quoted, after
// dropping a leading byte order mark.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Word
//  char      in         i_char_valid / o_char_ready   i_char_byte
//  tok       out        o_tok_valid / i_tok_ready     kind, token_byte, first, last
//
//  An accepted byte is scanned from the input register and its result words
//  load into the result register once it is free; unstalled, one word leaves
//  per cycle. A batch of n words (up to four after a broken mark) holds the
//  input until its last word leaves; unstalled, bytes of at most one word run
//  one per cycle. Synchronous active-low reset returns the scanner to line start, empty.
//  A stall on the output holds the result register and then the input one.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_command_line_tokenizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_char_valid,
    output logic            o_char_ready,
    input  wire logic [7:0] i_char_byte,
    output logic            o_tok_valid,
    input  wire logic       i_tok_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_token_byte,
    output logic            o_first_in_token,
    output logic            o_last_of_run
);
    import qct_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [2:0] r_mode;
    logic       r_has;
    logic [2:0] n_mode;
    logic       n_has;
    t_batch     batch;
    logic       can_load;
    logic       process;

    assign process      = r_in_valid && can_load;
    assign o_char_ready = !r_in_valid || can_load;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_char_ready) begin
            r_in_valid <= i_char_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_char_ready && i_char_valid) begin
            r_in_byte <= i_char_byte;
        end
    end

    // Scanner state, advanced once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINE_START;
            r_has  <= 1'b0;
        end else if (process) begin
            r_mode <= n_mode;
            r_has  <= n_has;
        end
    end

    qct_scan u_scan (
        .i_mode  (r_mode),
        .i_has   (r_has),
        .i_byte  (r_in_byte),
        .o_batch (batch),
        .o_mode  (n_mode),
        .o_has   (n_has)
    );

    qct_out_buf u_out_buf (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (process),
        .i_batch          (batch),
        .o_can_load       (can_load),
        .o_tok_valid      (o_tok_valid),
        .i_tok_ready      (i_tok_ready),
        .o_kind           (o_kind),
        .o_token_byte     (o_token_byte),
        .o_first_in_token (o_first_in_token),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

`default_nettype wire

[rtl/qct_scan.sv]
// ----------------------------------------------------------------------------
// qct_scan
// Single-pass scan of one byte: mark handling, replay of held mark bytes and
// the token scan, giving the next state and the byte's whole result batch.
// ----------------------------------------------------------------------------
`default_nettype none

module qct_scan (
    input  wire logic [2:0]      i_mode,
    input  wire logic            i_has,
    input  wire logic [7:0]      i_byte,
    output qct_pkg::t_batch      o_batch,
    output logic [2:0]           o_mode,
    output logic                 o_has
);
    import qct_pkg::*;

    logic       hold;
    logic [1:0] pre_cnt;
    logic [2:0] sc_mode;
    logic       sc_has;
    logic [1:0] sc_cnt;
    t_res       e0;
    t_res       e1;
    logic [2:0] nx_mode;
    logic       nx_has;
    logic [1:0] pos;
    logic [2:0] total;

    // Mark detection; replayed mark bytes leave a bare token with bytes.
    always_comb begin
        hold    = 1'b0;
        pre_cnt = 2'd0;
        sc_mode = MODE_GAP;
        sc_has  = i_has;
        unique case (i_mode)
            MODE_LINE_START: begin
                if (i_byte == MARK_B0) begin
                    hold = 1'b1;
                end
            end
            MODE_MARK_ONE: begin
                if (i_byte == MARK_B1) begin
                    hold = 1'b1;
                end else begin
                    pre_cnt = 2'd1;
                    sc_mode = MODE_BARE;
                    sc_has  = 1'b1;
                end
            end
            MODE_MARK_TWO: begin
                if (i_byte == MARK_B2) begin
                    hold = 1'b1;
                end else begin
                    pre_cnt = 2'd2;
                    sc_mode = MODE_BARE;
                    sc_has  = 1'b1;
                end
            end
            MODE_GAP, MODE_BARE, MODE_SINGLE, MODE_DOUBLE: begin
                sc_mode = i_mode;
            end
            default: begin
                sc_mode = MODE_GAP;
            end
        endcase
    end

    // Token scan of the current byte from the scan mode.
    always_comb begin
        sc_cnt  = 2'd0;
        e0      = '0;
        e1      = '0;
        nx_mode = sc_mode;
        nx_has  = 1'b0;
        case (sc_mode)
            MODE_BARE: begin
                if (i_byte == CH_NUL) begin
                    sc_cnt  = 2'd2;
                    e0.kind = KIND_END;
                    e1.kind = KIND_OK;
                    nx_mode = MODE_LINE_START;
                end else if (i_byte == CH_SPACE) begin
                    sc_cnt  = 2'd1;
                    e0.kind = KIND_END;
                    nx_mode = MODE_GAP;
                end else if (i_byte == CH_SQUOTE || i_byte == CH_DQUOTE) begin
                    sc_cnt  = 2'd1;
                    e0.kind = KIND_END;
                    nx_mode = (i_byte == CH_SQUOTE) ? MODE_SINGLE : MODE_DOUBLE;
                end else begin
                    sc_cnt            = 2'd1;
                    e0.kind           = KIND_BYTE;
                    e0.token_byte     = i_byte;
                    e0.first_in_token = !sc_has;
                    nx_has            = 1'b1;
                end
            end
            MODE_SINGLE, MODE_DOUBLE: begin
                if (i_byte == CH_NUL) begin
                    sc_cnt  = 2'd1;
                    e0.kind = KIND_ERROR;
                    nx_mode = MODE_LINE_START;
                end else if (i_byte == ((sc_mode == MODE_SINGLE) ? CH_SQUOTE : CH_DQUOTE)) begin
                    sc_cnt  = 2'd1;
                    e0.kind = KIND_END;
                    nx_mode = MODE_GAP;
                end else begin
                    sc_cnt            = 2'd1;
                    e0.kind           = KIND_BYTE;
                    e0.token_byte     = i_byte;
                    e0.first_in_token = !sc_has;
                    nx_has            = 1'b1;
                end
            end
            default: begin
                if (i_byte == CH_NUL) begin
                    sc_cnt  = 2'd1;
                    e0.kind = KIND_OK;
                    nx_mode = MODE_LINE_START;
                end else if (i_byte == CH_SPACE) begin
                    nx_mode = MODE_GAP;
                end else if (i_byte == CH_SQUOTE) begin
                    nx_mode = MODE_SINGLE;
                end else if (i_byte == CH_DQUOTE) begin
                    nx_mode = MODE_DOUBLE;
                end else begin
                    sc_cnt            = 2'd1;
                    e0.kind           = KIND_BYTE;
                    e0.token_byte     = i_byte;
                    e0.first_in_token = 1'b1;
                    nx_has            = 1'b1;
                    nx_mode           = MODE_BARE;
                end
            end
        endcase
    end

    // Assemble the batch: replayed mark bytes first, then the scan results.
    always_comb begin
        o_batch = '0;
        pos     = pre_cnt;
        total   = {1'b0, pre_cnt} + {1'b0, sc_cnt};
        o_batch.res[0].kind           = KIND_BYTE;
        o_batch.res[0].token_byte     = MARK_B0;
        o_batch.res[0].first_in_token = 1'b1;
        o_batch.res[1].kind           = KIND_BYTE;
        o_batch.res[1].token_byte     = MARK_B1;
        o_batch.res[pos]              = e0;
        o_batch.res[pos + 2'd1]       = e1;
        o_batch.num                   = hold ? 3'd0 : total;
        for (int i = 0; i < MAX_RES; i++) begin
            o_batch.res[i].last_of_run = (3'(i + 1) == o_batch.num);
        end
        if (hold) begin
            o_mode = (i_mode == MODE_LINE_START) ? MODE_MARK_ONE
                   : (i_mode == MODE_MARK_ONE) ? MODE_MARK_TWO : MODE_GAP;
            o_has  = i_has;
        end else begin
            o_mode = nx_mode;
            o_has  = nx_has;
        end
    end

endmodule

`default_nettype wire

[rtl/qct_out_buf.sv]
// ----------------------------------------------------------------------------
// qct_out_buf
// Result register: holds the batch of one input byte and hands it out one
// word per handshake. A new batch loads when it is empty or as the last word of the old one goes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quoted_command_line_tokenizer_defines.svh"

module qct_out_buf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire qct_pkg::t_batch i_batch,
    output logic                 o_can_load,
    output logic                 o_tok_valid,
    input  wire logic            i_tok_ready,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_token_byte,
    output logic                 o_first_in_token,
    output logic                 o_last_of_run
);
    import qct_pkg::*;

    t_res [MAX_RES-1:0] r_res;
    logic [2:0]         r_num;
    logic [1:0]         r_pos;
    logic               pop;
    logic               at_last;
    t_res               cur;

    assign cur          = r_res[r_pos];
    assign o_tok_valid  = (r_num != 3'd0);
    assign pop          = o_tok_valid && i_tok_ready;
    assign at_last      = (({1'b0, r_pos} + 3'd1) == r_num);
    assign o_can_load   = !o_tok_valid || (pop && at_last);

    assign o_kind           = cur.kind;
    assign o_token_byte     = cur.token_byte;
    assign o_first_in_token = cur.first_in_token;
    assign o_last_of_run    = cur.last_of_run;

    // Control: word count and read position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 3'd0;
            r_pos <= 2'd0;
        end else if (i_load) begin
            r_num <= i_batch.num;
            r_pos <= 2'd0;
        end else if (pop) begin
            if (at_last) begin
                r_num <= 3'd0;
                r_pos <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    // Payload: the words of the batch.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_batch.res;
        end
    end

    `QCT_ASSERT_NOW(a_no_overwrite, o_tok_valid && !(pop && at_last), !i_load,
        "batch loaded over words not yet delivered")
    `QCT_ASSERT_NOW(a_pos_in_range, o_tok_valid, ({1'b0, r_pos} < r_num) && (r_num <= 3'd4),
        "read position outside the batch")
    `QCT_ASSERT_NEXT(a_load_shows, i_load && (i_batch.num != 3'd0),
        o_tok_valid && (r_pos == 2'd0), "loaded batch not presented")
    `QCT_ASSERT_NEXT(a_drain_empty, pop && at_last && !i_load, !o_tok_valid,
        "output still valid after last word")

endmodule

`default_nettype wire
